// ----- design/ams_pkg.sv -----
package ams_pkg;

   // Sample and result widths
   localparam int IN_W    = 16;
   localparam int MAG_W   = 19;
   localparam int FRAC_W  = 16;
   localparam int RANGE_W = 2;
   localparam int ALPHA_W = 16;

   // Moving average window
   localparam int WIN_LEN = 5;
   localparam int SLOT_W  = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
   localparam int CNT_W   = $clog2(WIN_LEN + 1);
   localparam int SUM_W   = MAG_W + $clog2(WIN_LEN);

   // Derived datapath widths
   localparam int SQ_W    = 2 * IN_W;
   localparam int RAD_W   = SQ_W + 2 * ((1 << RANGE_W) - 1);
   localparam int SV_W    = MAG_W + FRAC_W;
   localparam int PROD_W  = SV_W + ALPHA_W;

   // Serial iteration counts; the divide is always the longer loop
   localparam int ROOT_ITER = RAD_W / 2;
   localparam int DIV_ITER  = SUM_W;
   localparam int ITER_W    = $clog2(DIV_ITER + 1);

   // Register file
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam int CSR_IDX_W = CSR_AW - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_RANGE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_ALPHA = 1'b1;
   localparam logic [RANGE_W-1:0]   RANGE_RST     = 2'd3;
   localparam logic [ALPHA_W-1:0]   ALPHA_RST     = 16'd13107;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ0,
      ST_SQ1,
      ST_SQ2,
      ST_SQ3,
      ST_ROOT,
      ST_WIN,
      ST_DIV,
      ST_FCMP,
      ST_FDIFF,
      ST_FMUL,
      ST_FUPD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range_sel;
      logic [ALPHA_W-1:0] alpha;
   } cfg_type;

   typedef struct packed {
      logic            ge;
      logic [SV_W-1:0] diff;
   } sub_res_type;

endpackage

// ----- design/ams_sub.sv -----
module ams_sub (
   input  logic [ams_pkg::SV_W-1:0] op_a,
   input  logic [ams_pkg::SV_W-1:0] op_b,
   output ams_pkg::sub_res_type     res
);
   import ams_pkg::*;

   logic [SV_W:0] wide_diff;

   // Subtract with borrow out; no borrow means op_a >= op_b
   assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
   assign res.ge    = ~wide_diff[SV_W];
   assign res.diff  = wide_diff[SV_W-1:0];

endmodule

// ----- design/ams_mul.sv -----
module ams_mul (
   input  logic                       clock,
   input  logic [ams_pkg::SV_W-1:0]    op_a,
   input  logic [ams_pkg::ALPHA_W-1:0] op_b,
   output logic [ams_pkg::PROD_W-1:0]  prod
);
   import ams_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   // Unsigned product, registered
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- design/ams_csr.sv -----
module ams_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [ams_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [ams_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [ams_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready,
   output ams_pkg::cfg_type           cfg
);
   import ams_pkg::*;

   logic [RANGE_W-1:0]   range_ff, range_in;
   logic [ALPHA_W-1:0]   alpha_ff, alpha_in;
   logic [CSR_IDX_W-1:0] idx;
   logic                 wr_en;

   assign idx   = csr_paddr[CSR_AW-1:2];
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   // Decode the write beat
   always_comb begin
      range_in = range_ff;
      alpha_in = alpha_ff;
      if (wr_en) begin
         case (idx)
            CSR_IDX_RANGE: range_in = csr_pwdata[RANGE_W-1:0];
            CSR_IDX_ALPHA: alpha_in = csr_pwdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= RANGE_RST;
         alpha_ff <= ALPHA_RST;
      end else begin
         range_ff <= range_in;
         alpha_ff <= alpha_in;
      end
   end

   // Read back
   always_comb begin
      case (idx)
         CSR_IDX_RANGE: csr_prdata = CSR_DW'(range_ff);
         CSR_IDX_ALPHA: csr_prdata = CSR_DW'(alpha_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign csr_pready    = 1'b1;
   assign cfg.range_sel = range_ff;
   assign cfg.alpha     = alpha_ff;

endmodule

// ----- design/accel_magnitude_smoother.sv -----
// The first sample after reset only seeds the low-pass filter and takes a shorter path
// to rsp_valid. A new sample is taken only once the previous one has left the sequencer;
// the pace is set by the square root (one bit pair per cycle) and the divide by the fill
// count (one quotient bit per cycle), both on the shared subtractor. A waiting result
// does not block the next beat. Window entries are not reset; there is no clearing pass.
// Reset: synchronous, clears the fill count, slot and sum, filter seed and handshake state.
module accel_magnitude_smoother (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [ams_pkg::IN_W-1:0] req_accel_x,
   input  logic signed [ams_pkg::IN_W-1:0] req_accel_y,
   input  logic signed [ams_pkg::IN_W-1:0] req_accel_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ams_pkg::MAG_W-1:0]    rsp_magnitude_g,
   output logic [ams_pkg::MAG_W-1:0]    rsp_average_g,
   output logic [ams_pkg::MAG_W-1:0]    rsp_filtered_g,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ams_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [ams_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [ams_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                        csr_pready
);
   import ams_pkg::*;

   cfg_type     cfg;
   sub_res_type sub_res;

   state_type state_ff, state_in;

   logic [IN_W-1:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [SQ_W-1:0]   acc_ff, acc_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [MAG_W-1:0]  root_ff, root_in;
   logic [MAG_W+1:0]  rem_ff, rem_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [MAG_W-1:0]  win_ff [WIN_LEN];
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  filled_ff, filled_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  dq_ff, dq_in;
   logic [CNT_W-1:0]  drem_ff, drem_in;
   logic [SV_W-1:0]   sv_ff, sv_in;
   logic              seeded_ff, seeded_in;
   logic              fge_ff, fge_in;
   logic [SV_W-1:0]   d_ff, d_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0]  rsp_mag_ff, rsp_mag_in;
   logic [MAG_W-1:0]  rsp_avg_ff, rsp_avg_in;
   logic [MAG_W-1:0]  rsp_filt_ff, rsp_filt_in;

   logic [SV_W-1:0]    sub_a, sub_b;
   logic [SV_W-1:0]    mul_a;
   logic [ALPHA_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod;

   logic              accept;
   logic              out_free;
   logic              win_full;
   logic [IN_W-1:0]   sel_axis;
   logic [IN_W-1:0]   abs_axis;
   logic [SQ_W-1:0]   sq_sum;
   logic [MAG_W+3:0]  rem_sh;
   logic [CNT_W:0]    drem_sh;
   logic [SV_W-1:0]   target;
   logic [SV_W-1:0]   step_q;
   logic              step_round;

   ams_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ams_sub u_sub (
      .op_a (sub_a),
      .op_b (sub_b),
      .res  (sub_res)
   );

   ams_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign win_full  = (filled_ff == CNT_W'(WIN_LEN));

   // Shared helpers for the datapath
   always_comb begin
      case (state_ff)
         ST_SQ0:  sel_axis = x_ff;
         ST_SQ1:  sel_axis = y_ff;
         default: sel_axis = z_ff;
      endcase
   end

   assign abs_axis   = sel_axis[IN_W-1] ? (~sel_axis + 1'b1) : sel_axis;
   assign sq_sum     = acc_ff + prod[SQ_W-1:0];
   assign rem_sh     = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign drem_sh    = {drem_ff, dq_ff[SUM_W-1]};
   assign target     = {dq_ff[MAG_W-1:0], {FRAC_W{1'b0}}};
   assign step_q     = prod[PROD_W-1:FRAC_W];
   assign step_round = |prod[FRAC_W-1:0];

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_SQ0;
         ST_SQ0:   state_in = ST_SQ1;
         ST_SQ1:   state_in = ST_SQ2;
         ST_SQ2:   state_in = ST_SQ3;
         ST_SQ3:   state_in = ST_ROOT;
         ST_ROOT:  if (iter_ff == ITER_W'(ROOT_ITER - 1)) state_in = ST_WIN;
         ST_WIN:   state_in = ST_DIV;
         ST_DIV:   if (iter_ff == ITER_W'(DIV_ITER - 1)) state_in = ST_FCMP;
         ST_FCMP:  state_in = seeded_ff ? ST_FDIFF : ST_OUT;
         ST_FDIFF: state_in = ST_FMUL;
         ST_FMUL:  state_in = ST_FUPD;
         ST_FUPD:  state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Unit operands and register next values per step
   always_comb begin
      sub_a        = '0;
      sub_b        = '0;
      mul_a        = '0;
      mul_b        = '0;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      iter_in      = iter_ff;
      slot_in      = slot_ff;
      filled_in    = filled_ff;
      sum_in       = sum_ff;
      dq_in        = dq_ff;
      drem_in      = drem_ff;
      sv_in        = sv_ff;
      seeded_in    = seeded_ff;
      fge_in       = fge_ff;
      d_in         = d_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_filt_in  = rsp_filt_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            // Capture the sample beat
            if (accept) begin
               x_in = req_accel_x;
               y_in = req_accel_y;
               z_in = req_accel_z;
            end
         end
         ST_SQ0: begin
            mul_a = SV_W'(abs_axis);
            mul_b = ALPHA_W'(abs_axis);
         end
         ST_SQ1, ST_SQ2: begin
            // Accumulate the previous square, issue the next one
            acc_in = (state_ff == ST_SQ1) ? prod[SQ_W-1:0] : sq_sum;
            mul_a  = SV_W'(abs_axis);
            mul_b  = ALPHA_W'(abs_axis);
         end
         ST_SQ3: begin
            // Scale to Q14 by shifting the radicand two bits per range step
            rad_in  = RAD_W'(sq_sum) << {cfg.range_sel, 1'b0};
            root_in = '0;
            rem_in  = '0;
            iter_in = '0;
         end
         ST_ROOT: begin
            // One root bit per cycle: trial subtract of {root, 01}
            sub_a   = SV_W'(rem_sh);
            sub_b   = SV_W'({root_ff, 2'b01});
            rad_in  = rad_ff << 2;
            iter_in = iter_ff + 1'b1;
            if (sub_res.ge) begin
               rem_in  = sub_res.diff[MAG_W+1:0];
               root_in = {root_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[MAG_W+1:0];
               root_in = {root_ff[MAG_W-2:0], 1'b0};
            end
         end
         ST_WIN: begin
            // Replace the oldest entry once the window is full
            sum_in    = sum_ff - (win_full ? SUM_W'(win_ff[slot_ff]) : '0)
                        + SUM_W'(root_ff);
            filled_in = win_full ? filled_ff : filled_ff + 1'b1;
            slot_in   = (slot_ff == SLOT_W'(WIN_LEN - 1)) ? '0 : slot_ff + 1'b1;
            dq_in     = sum_in;
            drem_in   = '0;
            iter_in   = '0;
         end
         ST_DIV: begin
            // Restoring divide by the fill count, one quotient bit per cycle
            sub_a   = SV_W'(drem_sh);
            sub_b   = SV_W'(filled_ff);
            iter_in = iter_ff + 1'b1;
            dq_in   = {dq_ff[SUM_W-2:0], sub_res.ge};
            drem_in = sub_res.ge ? sub_res.diff[CNT_W-1:0] : drem_sh[CNT_W-1:0];
         end
         ST_FCMP: begin
            // Seed on the first average, else find the step direction
            sub_a  = target;
            sub_b  = sv_ff;
            fge_in = sub_res.ge;
            if (!seeded_ff) begin
               sv_in     = target;
               seeded_in = 1'b1;
            end
         end
         ST_FDIFF: begin
            sub_a = fge_ff ? target : sv_ff;
            sub_b = fge_ff ? sv_ff : target;
            d_in  = sub_res.diff;
         end
         ST_FMUL: begin
            mul_a = d_ff;
            mul_b = cfg.alpha;
         end
         ST_FUPD: begin
            // Step up truncated, step down rounded away so the state floors
            sv_in = fge_ff ? (sv_ff + step_q) : (sv_ff - step_q - SV_W'(step_round));
         end
         ST_OUT: begin
            // Load the result beat once the output register is free
            if (out_free) begin
               rsp_mag_in   = root_ff;
               rsp_avg_in   = dq_ff[MAG_W-1:0];
               rsp_filt_in  = sv_ff[SV_W-1:FRAC_W];
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         filled_ff    <= '0;
         sum_ff       <= '0;
         sv_ff        <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         filled_ff    <= filled_in;
         sum_ff       <= sum_in;
         sv_ff        <= sv_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      acc_ff      <= acc_in;
      rad_ff      <= rad_in;
      root_ff     <= root_in;
      rem_ff      <= rem_in;
      iter_ff     <= iter_in;
      dq_ff       <= dq_in;
      drem_ff     <= drem_in;
      fge_ff      <= fge_in;
      d_ff        <= d_in;
      rsp_mag_ff  <= rsp_mag_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_filt_ff <= rsp_filt_in;
   end

   // Window entries are only read once all of them have been written
   always_ff @(posedge clock) begin
      if (state_ff == ST_WIN) begin
         win_ff[slot_ff] <= root_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_magnitude_g = rsp_mag_ff;
   assign rsp_average_g   = rsp_avg_ff;
   assign rsp_filtered_g  = rsp_filt_ff;

   // An accepted beat always starts the square step
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SQ0))
      else $error("accepted beat did not start the sequencer");

   // A result appears only from the output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   // Divide remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (drem_ff < filled_ff))
      else $error("divide remainder not below fill count");

   // Fill count never passes the window length
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WIN) |=> (filled_ff <= CNT_W'(WIN_LEN) && filled_ff != '0))
      else $error("fill count out of range after window update");

endmodule
